// ===== rtl/ksc_pkg.sv =====
// Shared types and constants for the k-mer seed chaining filter.
// No dependencies.
package ksc_pkg;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	localparam logic [1:0] REG_WINDOW = 2'd0;
	localparam logic [1:0] REG_EDITS  = 2'd1;
	localparam logic [1:0] REG_START  = 2'd2;

	// one classified command from front to back
	typedef struct packed {
		logic       op;
		logic [5:0] slot;
		logic [9:0] pos;
	} cmd_t;

	// one result item
	typedef struct packed {
		logic       matched;
		logic [7:0] edit_count;
		logic [6:0] matched_kmers;
		logic [5:0] query_start;
		logic [9:0] read_start;
		logic       overflow;
	} res_t;

endpackage

// ===== rtl/kmer_seed_chain_filter.sv =====
// Top level of the k-mer seed chaining filter.
// Depends on ksc_pkg, ksc_front and ksc_back.
//
// Usage:
//  s_axis carries items: tdata = {read_pos, kmer_slot}, tuser = op.
//  A load appends a hit to its slot list: the back end reads the count,
//  then writes, and takes no new transfer until the write is done.
//  An evaluate walks the lists and returns one result on m_axis. It reads
//  the count of each start slot tried, then each start entry, then the
//  count and candidates of each walked slot, and ends in S_DONE after a
//  match or once the start slots run out.
//  Each memory has a single read port, so entries are walked one at a time.
//  A two-entry queue separates the front from the back; while a result
//  waits the back end stops and the queue takes up to two more transfers.
//  Reset clears the slot valid bits, overflow flag and state; an evaluate
//  clears all valid bits at once in S_DONE, so no clearing pass is needed.
//  When m_axis stalls the result holds until it is taken.
//  Configuration: cfg_we, cfg_addr (0 window, 1 edits, 2 start limit).
module kmer_seed_chain_filter #(
	parameter int NUM_SLOTS = 64,
	parameter int MAX_HITS  = 8,
	parameter int POS_BITS  = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // kmer_slot[5:0], read_pos[15:6]
	input  logic        s_axis_tuser,  // op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // matched, edit_count, matched_kmers,
	                                   // query_start, read_start, overflow
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [6:0]  cfg_wdata
);

	logic [6:0] win_q, lim_q;
	logic [3:0] ed_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= 7'd8;
			ed_q  <= 4'd2;
			lim_q <= 7'd32;
		end else if (cfg_we) begin
			case (cfg_addr)
				ksc_pkg::REG_WINDOW: win_q <= cfg_wdata;
				ksc_pkg::REG_EDITS:  ed_q  <= cfg_wdata[3:0];
				ksc_pkg::REG_START:  lim_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	ksc_pkg::cmd_t in_cmd, q_cmd;
	ksc_pkg::res_t res;
	logic          q_valid, q_ready;

	assign in_cmd.op   = s_axis_tuser;
	assign in_cmd.slot = s_axis_tdata[5:0];
	assign in_cmd.pos  = s_axis_tdata[15:6];

	ksc_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd(in_cmd),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
	);

	ksc_back #(.NUM_SLOTS(NUM_SLOTS), .MAX_HITS(MAX_HITS), .POS_BITS(POS_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
		.window_size(win_q), .allowed_edits(ed_q), .start_limit(lim_q),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
	);

	assign m_axis_tdata = {7'd0, res.overflow, res.read_start, res.query_start,
		res.matched_kmers, res.edit_count, res.matched};

endmodule

// ===== rtl/ksc_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module ksc_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/ksc_front.sv =====
// Front end: accepts input transfers and queues them for the back end.
// Depends on ksc_pkg.
module ksc_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ksc_pkg::cmd_t in_cmd,
	output logic          q_valid,
	input  logic          q_ready,
	output ksc_pkg::cmd_t q_cmd
);

	// two-entry queue
	ksc_pkg::cmd_t ent_q [2];
	logic          rd_q, wr_q;
	logic [1:0]    cnt_q;
	logic          push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_cmd    = ent_q[rd_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= in_cmd;
	end

endmodule

// ===== rtl/ksc_back.sv =====
// Back end: hit store, per-slot counts and the chaining walk sequencer.
// Depends on ksc_pkg and ksc_ram.
module ksc_back #(
	parameter int NUM_SLOTS = 64,
	parameter int MAX_HITS  = 8,
	parameter int POS_BITS  = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_ready,
	input  ksc_pkg::cmd_t q_cmd,
	input  logic [6:0]    window_size,
	input  logic [3:0]    allowed_edits,
	input  logic [6:0]    start_limit,
	output logic          res_valid,
	input  logic          res_ready,
	output ksc_pkg::res_t res
);

	localparam int SB = $clog2(NUM_SLOTS);
	localparam int HB = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
	localparam int CB = $clog2(MAX_HITS + 1);
	localparam int JB = SB + 1;
	localparam int AB = $clog2(NUM_SLOTS * MAX_HITS);
	localparam int EB = 9;

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_ICNT, S_IWAIT, S_START, S_SRD,
		S_JCNT, S_JWAIT, S_STEP, S_KRD, S_DONE
	} state_t;

	state_t state_q;
	logic [NUM_SLOTS-1:0] vld_q;
	logic                 ovf_q;
	logic [JB-1:0]        i_q, j_q, lim_q;
	logic [CB-1:0]        h_q, k_q, ci_q, cj_q;
	logic [SB-1:0]        ld_slot_q;
	logic [POS_BITS-1:0]  ld_pos_q;
	logic [POS_BITS-1:0]  start_q, prev_q;
	logic [EB-1:0]        edits_q;
	logic [7:0]           matched_q;
	ksc_pkg::res_t        res_q;
	logic                 rv_q;

	// RAM ports
	logic                we;
	logic [AB-1:0]       waddr, raddr;
	logic [POS_BITS-1:0] rdata;
	logic [SB-1:0]       craddr;
	logic [CB-1:0]       crdata, lcnt, cwdata;

	logic [JB+1:0]       wend;
	logic [POS_BITS:0]   hi_lim;
	logic                in_rng;
	logic [EB-1:0]       ed_fix;
	logic signed [8:0]   need;
	logic                walk_end;
	logic                chain_ok;

	// count of the slot being loaded; a slot cleared since its last load reads as empty
	assign lcnt    = vld_q[ld_slot_q] ? crdata : '0;
	assign cwdata  = lcnt + 1'b1;
	assign q_ready = (state_q == S_IDLE) && !rv_q;
	assign we      = (state_q == S_LOAD) && (32'(lcnt) < 32'(MAX_HITS));
	assign waddr   = AB'(32'(ld_slot_q) * MAX_HITS + 32'(lcnt));

	ksc_ram #(.WIDTH(POS_BITS), .DEPTH(NUM_SLOTS * MAX_HITS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(ld_pos_q), .raddr(raddr), .rdata(rdata)
	);

	ksc_ram #(.WIDTH(CB), .DEPTH(NUM_SLOTS)) u_cnt_ram (
		.clk(clk), .we(we), .waddr(ld_slot_q), .wdata(cwdata), .raddr(craddr),
		.rdata(crdata)
	);

	// count read address: incoming load, start slot or walked slot
	always_comb begin
		case (state_q)
			S_IDLE:  craddr = SB'(q_cmd.slot);
			S_ICNT:  craddr = i_q[SB-1:0];
			default: craddr = j_q[SB-1:0];
		endcase
	end

	// hit read address: start entry or candidate entry
	always_comb begin
		if (state_q == S_START)
			raddr = AB'(32'(i_q[SB-1:0]) * MAX_HITS + 32'(h_q[HB-1:0]));
		else
			raddr = AB'(32'(j_q[SB-1:0]) * MAX_HITS + 32'(k_q[HB-1:0]));
	end

	assign wend     = (JB+2)'(i_q) + (JB+2)'(window_size);
	assign hi_lim   = {1'b0, prev_q} + (POS_BITS+1)'(allowed_edits);
	assign in_rng   = (rdata > prev_q) && ({1'b0, rdata} <= hi_lim);
	assign need     = $signed({2'b0, window_size}) - $signed({5'b0, allowed_edits});
	assign walk_end = ((JB+2)'(j_q) >= wend) || (32'(j_q) >= 32'(NUM_SLOTS))
		|| (edits_q > EB'(allowed_edits));
	assign chain_ok = $signed({1'b0, matched_q}) >= need;

	always_comb begin
		ed_fix = edits_q;
		if ({1'b0, matched_q} < {1'b0, window_size} && edits_q == '0)
			ed_fix = EB'(window_size) - EB'(matched_q);
	end

	assign res_valid = rv_q;
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vld_q <= '0;
			ovf_q <= 1'b0;
			rv_q  <= 1'b0;
			i_q <= '0; j_q <= '0; h_q <= '0; k_q <= '0; lim_q <= '0;
			ci_q <= '0; cj_q <= '0;
		end else begin
			if (rv_q && res_ready) rv_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_valid && q_ready) begin
						if (q_cmd.op == ksc_pkg::OP_LOAD) begin
							ld_slot_q <= SB'(q_cmd.slot);
							ld_pos_q  <= POS_BITS'(q_cmd.pos);
							if ({26'd0, q_cmd.slot} < 32'(NUM_SLOTS)) state_q <= S_LOAD;
						end else begin
							lim_q   <= (32'(start_limit) < NUM_SLOTS) ? JB'(start_limit)
								: JB'(NUM_SLOTS);
							i_q     <= '0;
							h_q     <= '0;
							res_q   <= '0;
							state_q <= S_ICNT;
						end
					end
				end
				// append the hit, or flag it dropped when the slot is full
				S_LOAD: begin
					if (we) vld_q[ld_slot_q] <= 1'b1;
					else ovf_q <= 1'b1;
					state_q <= S_IDLE;
				end
				// fetch the count of the next start slot, or finish
				S_ICNT: begin
					if (i_q >= lim_q) state_q <= S_DONE;
					else state_q <= S_IWAIT;
				end
				S_IWAIT: begin
					ci_q    <= vld_q[i_q[SB-1:0]] ? crdata : '0;
					state_q <= S_START;
				end
				// next start entry of this slot, or move to the next slot
				S_START: begin
					if (h_q >= ci_q) begin
						i_q     <= i_q + 1'b1;
						h_q     <= '0;
						state_q <= S_ICNT;
					end else begin
						state_q <= S_SRD;
					end
				end
				S_SRD: begin
					start_q   <= rdata;
					prev_q    <= rdata;
					edits_q   <= '0;
					matched_q <= 8'd1;
					j_q       <= i_q + 1'b1;
					k_q       <= '0;
					state_q   <= S_JCNT;
				end
				// end of the walk, or fetch the count of the next slot
				S_JCNT: begin
					if (walk_end) begin
						if (chain_ok) begin
							res_q.matched       <= 1'b1;
							res_q.edit_count    <= (ed_fix > 9'd255) ? 8'd255 : ed_fix[7:0];
							res_q.matched_kmers <= matched_q[6:0];
							res_q.query_start   <= 6'(i_q);
							res_q.read_start    <= 10'(start_q);
							state_q <= S_DONE;
						end else begin
							h_q     <= h_q + 1'b1;
							state_q <= S_START;
						end
					end else begin
						state_q <= S_JWAIT;
					end
				end
				S_JWAIT: begin
					cj_q    <= vld_q[j_q[SB-1:0]] ? crdata : '0;
					state_q <= S_STEP;
				end
				// next candidate of the walked slot, or count a miss
				S_STEP: begin
					if (k_q >= cj_q) begin
						edits_q <= edits_q + 1'b1;
						j_q     <= j_q + 1'b1;
						k_q     <= '0;
						state_q <= S_JCNT;
					end else begin
						state_q <= S_KRD;
					end
				end
				S_KRD: begin
					if (in_rng) begin
						edits_q   <= edits_q + EB'(rdata - prev_q - 1'b1);
						prev_q    <= rdata;
						matched_q <= matched_q + 1'b1;
						j_q       <= j_q + 1'b1;
						k_q       <= '0;
						state_q   <= S_JCNT;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_STEP;
					end
				end
				// present the result and clear the store
				S_DONE: begin
					res_q.overflow <= ovf_q;
					rv_q    <= 1'b1;
					ovf_q   <= 1'b0;
					vld_q   <= '0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/ksc_checker.sv =====
// Port-level checker for the filter, bound to the top level.
// Depends on kmer_seed_chain_filter ports only.
module ksc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata
);

	// a waiting result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// no match means zero chain fields; overflow may still be set
	a_nomatch: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[31:1] == '0)
		else $error("unmatched result carries data");

	// a match has at least one k-mer
	a_kmers: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[15:9] != '0)
		else $error("match with no k-mers");

	// padding stays zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[39:33] == '0)
		else $error("padding not zero");

endmodule

bind kmer_seed_chain_filter ksc_checker u_ksc_checker (
	.clk(clk), .arst_n(arst_n), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
